// File: hdl/primitive_index_assembler_unit_defines.svh
// assertion macros for the primitive index assembler
// depends on clk and rst_n being in scope where the macros are used
`ifndef PRIMITIVE_INDEX_ASSEMBLER_UNIT_DEFINES_SVH
`define PRIMITIVE_INDEX_ASSEMBLER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define PIA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("primitive index assembler check failed");
// next-cycle implication, disabled during reset
`define PIA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("primitive index assembler check failed");
`else
`define PIA_ASSERT_SAME(lbl, ante, cons)
`define PIA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/pia_pkg.sv
// shared types and constants of the primitive index assembler
// no dependencies
package pia_pkg;

    // kept bits of each vertex index (16 to 32)
    localparam int INDEX_BITS = 32;

    // tag and count widths
    localparam int WORD_BITS = 32;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE     = 2'd0,
        REG_VCOUNT   = 2'd1,
        REG_MATERIAL = 2'd2,
        REG_RECORD   = 2'd3
    } reg_index_t;

    // assembly modes
    typedef enum logic [1:0] {
        MODE_LIST  = 2'd0,
        MODE_STRIP = 2'd1,
        MODE_FAN   = 2'd2,
        MODE_QUADS = 2'd3
    } mode_t;

    typedef logic [INDEX_BITS-1:0] index_t;

    typedef struct packed {
        mode_t                mode;
        logic [WORD_BITS-1:0] vertex_count;
        logic [WORD_BITS-1:0] material;
        logic [WORD_BITS-1:0] record;
    } cfg_t;

    // one triangle as stored in the result queue
    typedef struct packed {
        index_t a;
        index_t b;
        index_t c;
        logic   last;
    } tri_t;

    // triangles handed to the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        tri_t       first;
        tri_t       second;
    } push_t;

    // queue status back to the assembly stage
    typedef struct packed {
        logic [QCNT_BITS-1:0] count;
        logic                 room;
    } q_status_t;

endpackage

// File: hdl/pia_cfg.sv
// configuration registers of the primitive index assembler
// depends on pia_pkg
module pia_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pia_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pia_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output pia_pkg::cfg_t                       cfg
);

    pia_pkg::cfg_t cfg_reg;
    pia_pkg::cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (pia_pkg::reg_index_t'(cfg_index))
                pia_pkg::REG_MODE:     cfg_next.mode = pia_pkg::mode_t'(cfg_data[1:0]);
                pia_pkg::REG_VCOUNT:   cfg_next.vertex_count = cfg_data;
                pia_pkg::REG_MATERIAL: cfg_next.material = cfg_data;
                pia_pkg::REG_RECORD:   cfg_next.record = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= pia_pkg::MODE_LIST;
            cfg_reg.vertex_count <= '0;
            cfg_reg.material     <= '0;
            cfg_reg.record       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/pia_assemble.sv
// input register, assembly state and triangle forming logic
// depends on pia_pkg
module pia_assemble
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  pia_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pia_pkg::WORD_BITS-1:0]  vertex_index,
    input  logic                           set_end,
    input  pia_pkg::q_status_t             q_status,
    output pia_pkg::push_t                 push
);

    // input register
    logic            hold_valid_reg;
    logic            hold_valid_next;
    pia_pkg::index_t hold_index_reg;
    logic            hold_end_reg;

    // assembly state
    logic [1:0]      phase_reg;
    logic [1:0]      phase_next;
    logic            odd_reg;
    logic            odd_next;
    pia_pkg::index_t held_reg [3];
    pia_pkg::index_t held_next [3];

    logic            accept;
    logic            process;
    pia_pkg::index_t x;
    logic            ok0, ok1, ok2, okx;
    pia_pkg::tri_t   t0, t1;
    logic            k0, k1;

    assign in_stall = hold_valid_reg && !q_status.room;
    assign accept   = in_valid && !in_stall;
    assign process  = hold_valid_reg && q_status.room;
    assign x        = hold_index_reg;

    // input register control
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
            hold_valid_next = 1'b1;
        else if (process)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_index_reg <= vertex_index[pia_pkg::INDEX_BITS-1:0];
            hold_end_reg   <= set_end;
        end
    end

    // culling compares, one per distinct corner
    assign ok0 = pia_pkg::WORD_BITS'(held_reg[0]) < cfg.vertex_count;
    assign ok1 = pia_pkg::WORD_BITS'(held_reg[1]) < cfg.vertex_count;
    assign ok2 = pia_pkg::WORD_BITS'(held_reg[2]) < cfg.vertex_count;
    assign okx = pia_pkg::WORD_BITS'(x) < cfg.vertex_count;

    // triangle forming and state update
    always_comb
    begin
        phase_next = phase_reg;
        odd_next   = odd_reg;
        held_next  = held_reg;
        t0         = '{a: held_reg[0], b: held_reg[1], c: x, last: 1'b0};
        t1         = '{a: held_reg[0], b: held_reg[2], c: x, last: 1'b1};
        k0         = 1'b0;
        k1         = 1'b0;

        case (cfg.mode)
            pia_pkg::MODE_LIST:
            begin
                if (phase_reg[1])
                begin
                    k0         = ok0 && ok1 && okx;
                    phase_next = 2'd0;
                end
                else
                begin
                    held_next[phase_reg] = x;
                    phase_next           = phase_reg + 2'd1;
                end
            end
            pia_pkg::MODE_STRIP:
            begin
                if (phase_reg[1])
                begin
                    if (odd_reg)
                    begin
                        t0.a = held_reg[1];
                        t0.b = held_reg[0];
                    end
                    k0           = ok0 && ok1 && okx;
                    odd_next     = !odd_reg;
                    held_next[0] = held_reg[1];
                    held_next[1] = x;
                    phase_next   = 2'd2;
                end
                else
                begin
                    held_next[phase_reg] = x;
                    phase_next           = phase_reg + 2'd1;
                end
            end
            pia_pkg::MODE_FAN:
            begin
                if (phase_reg[1])
                begin
                    k0           = ok0 && ok1 && okx;
                    held_next[1] = x;
                    phase_next   = 2'd2;
                end
                else
                begin
                    held_next[phase_reg] = x;
                    phase_next           = phase_reg + 2'd1;
                end
            end
            default:
            begin
                // quads: a full quad emits both halves; the second half closes on the new index
                if (phase_reg == 2'd3)
                begin
                    t0.c       = held_reg[2];
                    k0         = ok0 && ok1 && ok2;
                    k1         = ok0 && ok2 && okx;
                    phase_next = 2'd0;
                end
                else
                begin
                    case (phase_reg)
                        2'd0:    held_next[0] = x;
                        2'd1:    held_next[1] = x;
                        default: held_next[2] = x;
                    endcase
                    phase_next = phase_reg + 2'd1;
                end
            end
        endcase

        // end of set returns to the empty state
        if (hold_end_reg)
        begin
            phase_next = 2'd0;
            odd_next   = 1'b0;
            held_next  = '{default: '0};
        end
    end

    // pack surviving triangles into queue order, last one marked
    always_comb
    begin
        push.first  = t0;
        push.second = t1;
        push.count  = 2'd0;
        if (process)
        begin
            if (k0)
            begin
                push.first.last = !k1;
                push.count      = k1 ? 2'd2 : 2'd1;
            end
            else if (k1)
            begin
                push.first = t1;
                push.count = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            odd_reg   <= 1'b0;
            held_reg  <= '{default: '0};
        end
        else if (process)
        begin
            phase_reg <= phase_next;
            odd_reg   <= odd_next;
            held_reg  <= held_next;
        end
    end

endmodule

// File: hdl/pia_out_queue.sv
// result queue: takes up to two triangles a cycle, delivers one a cycle while pop is high
// depends on pia_pkg
module pia_out_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  pia_pkg::push_t     push,
    input  logic               pop,
    output pia_pkg::q_status_t q_status,
    output logic               head_valid,
    output pia_pkg::tri_t      head
);

    pia_pkg::tri_t                   entry_reg [pia_pkg::QUEUE_DEPTH];
    logic [pia_pkg::QPTR_BITS-1:0]   head_reg;
    logic [pia_pkg::QPTR_BITS-1:0]   head_next;
    logic [pia_pkg::QPTR_BITS-1:0]   tail_reg;
    logic [pia_pkg::QPTR_BITS-1:0]   tail_next;
    logic [pia_pkg::QPTR_BITS-1:0]   tail_plus1;
    logic [pia_pkg::QCNT_BITS-1:0]   count_reg;
    logic [pia_pkg::QCNT_BITS-1:0]   count_next;

    assign tail_plus1 = tail_reg + pia_pkg::QPTR_BITS'(1);

    // pointer and fill count update
    always_comb
    begin
        tail_next  = tail_reg + pia_pkg::QPTR_BITS'(push.count);
        head_next  = pop ? head_reg + pia_pkg::QPTR_BITS'(1) : head_reg;
        count_next = count_reg + pia_pkg::QCNT_BITS'(push.count)
                     - pia_pkg::QCNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // entry writes
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[tail_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[tail_plus1] <= push.second;
    end

    assign head_valid     = count_reg != '0;
    assign head           = entry_reg[head_reg];
    assign q_status.count = count_reg;
    assign q_status.room  = count_reg <= pia_pkg::QCNT_BITS'(pia_pkg::QUEUE_DEPTH - 2);

endmodule

// File: hdl/primitive_index_assembler_unit.sv
// top level of the primitive index assembler
// depends on pia_pkg, pia_cfg, pia_assemble, pia_out_queue and the defines header

// Turns a stream of vertex indices into triangle index triples in list, strip, fan
// or quad mode. One index is accepted per cycle while in_stall is low; an index
// enters an input register, is assembled against the held corners once the queue
// has room, and its zero to two triangles land in a four-entry result queue.
// Triangles leave at one per cycle while out_stall is low; the queue takes new work
// while it has room for two entries, which sustains one index per cycle in every
// mode while the output is not stalled. Triangles with a corner at or above
// vertex_count are culled and each result carries the material and record tags. The
// user must make configuration writes while the block is idle; it is not enforced.
`include "primitive_index_assembler_unit_defines.svh"

module primitive_index_assembler_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pia_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pia_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pia_pkg::WORD_BITS-1:0]       vertex_index,
    input  logic                                set_end,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pia_pkg::WORD_BITS-1:0]       corner_a,
    output logic [pia_pkg::WORD_BITS-1:0]       corner_b,
    output logic [pia_pkg::WORD_BITS-1:0]       corner_c,
    output logic [pia_pkg::WORD_BITS-1:0]       material_out,
    output logic [pia_pkg::WORD_BITS-1:0]       record_out,
    output logic                                run_last
);

    pia_pkg::cfg_t      cfg;
    pia_pkg::push_t     push;
    pia_pkg::q_status_t q_status;
    pia_pkg::tri_t      head;
    logic               pop;

    // configuration registers
    pia_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register and assembly
    pia_assemble u_assemble
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .vertex_index (vertex_index),
        .set_end      (set_end),
        .q_status     (q_status),
        .push         (push)
    );

    // result queue, one transfer per cycle while out_stall is low
    assign pop = out_valid && !out_stall;

    pia_out_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .q_status   (q_status),
        .head_valid (out_valid),
        .head       (head)
    );

    // result fields; tags come live from cfg and stay stable only while it is not written
    assign corner_a     = pia_pkg::WORD_BITS'(head.a);
    assign corner_b     = pia_pkg::WORD_BITS'(head.b);
    assign corner_c     = pia_pkg::WORD_BITS'(head.c);
    assign run_last     = head.last;
    assign material_out = cfg.material;
    assign record_out   = cfg.record;

    // checks
    `PIA_ASSERT_SAME(a_queue_bound, 1'b1, q_status.count <= pia_pkg::QCNT_BITS'(pia_pkg::QUEUE_DEPTH))
    `PIA_ASSERT_SAME(a_push_fits, push.count != 2'd0, q_status.room)
    `PIA_ASSERT_SAME(a_pair_last, push.count == 2'd2, !push.first.last && push.second.last)
    `PIA_ASSERT_NEXT(a_empty_stays, (q_status.count == '0) && (push.count == 2'd0), !out_valid)

endmodule
